FILE: hw/rtl/pwle_pkg.sv
package pwle_pkg;

  // field and register widths
  localparam int unsigned DataW     = 64;
  localparam int unsigned CntW      = 5;
  localparam int unsigned EntryIdxW = 4;

  // default table depth
  localparam int unsigned MaxSegmentsDef = 16;

  // queue depths: the result queue must cover the back pipeline plus one
  localparam int unsigned MidQDepth = 2;
  localparam int unsigned OutQDepth = 8;
  localparam int unsigned OutCntW   = $clog2(OutQDepth + 1);

  localparam logic signed [DataW-1:0] KInt64Max = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [DataW-1:0] KInt64Min = 64'sh8000_0000_0000_0000;

  typedef enum logic {
    OpWrite = 1'b0,
    OpEval  = 1'b1
  } pwle_op_e;

  // evaluation job handed from the front to the back
  typedef struct packed {
    logic                    in_domain;
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] rx;
    logic signed [DataW-1:0] ry;
    logic signed [DataW-1:0] slope;
  } pwle_job_t;

  // one result item
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    in_domain;
  } pwle_res_t;

endpackage

FILE: hw/rtl/pwle_queue.sv
module pwle_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = data_q[rd_ptr_q];

  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      data_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hw/rtl/pwle_front.sv
module pwle_front import pwle_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = MaxSegmentsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  output logic                    full_o,
  input  logic                    op_i,
  input  logic [EntryIdxW-1:0]    entry_index_i,
  input  logic signed [DataW-1:0] start_x_i,
  input  logic signed [DataW-1:0] end_x_i,
  input  logic signed [DataW-1:0] ref_x_i,
  input  logic signed [DataW-1:0] ref_y_i,
  input  logic signed [DataW-1:0] slope_i,
  input  logic signed [DataW-1:0] query_x_i,
  input  logic                    cfg_we_i,
  input  logic [CntW-1:0]         cfg_wdata_i,
  output logic                    job_valid_o,
  output pwle_job_t               job_o,
  input  logic                    job_full_i
);

  // only slots reachable by the entry index can ever be written
  localparam int unsigned NumSlots =
      (MAX_SEGMENTS < (2 ** EntryIdxW)) ? MAX_SEGMENTS : (2 ** EntryIdxW);
  localparam int unsigned SlotW = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  logic signed [DataW-1:0] start_q [NumSlots];
  logic signed [DataW-1:0] end_q   [NumSlots];
  logic signed [DataW-1:0] refx_q  [NumSlots];
  logic signed [DataW-1:0] refy_q  [NumSlots];
  logic signed [DataW-1:0] slope_q [NumSlots];

  logic [CntW-1:0] seg_cnt_q;
  logic [CntW-1:0] eff_cnt;

  // input stage
  logic                    s0_v_q;
  pwle_op_e                s0_op_q;
  logic [EntryIdxW-1:0]    s0_idx_q;
  logic signed [DataW-1:0] s0_start_q, s0_end_q, s0_refx_q, s0_refy_q, s0_slope_q;
  logic signed [DataW-1:0] s0_x_q;

  // classify stage
  logic                    s1_v_q;
  logic                    s1_any_q;
  logic [SlotW-1:0]        s1_found_q;
  logic signed [DataW-1:0] s1_x_q;

  logic                    s0_adv, s1_adv, accept;
  logic                    tbl_we;
  logic [SlotW-1:0]        wr_slot;
  logic [NumSlots-1:0]     hit;
  logic [SlotW-1:0]        found;
  logic                    any;

  assign s1_adv = !s1_v_q || !job_full_i;
  assign s0_adv = !s0_v_q || s1_adv;
  assign full_o = !s0_adv;
  assign accept = push_i && s0_adv;

  // table write retires from the input stage, after any older query has read
  assign tbl_we  = s0_v_q && (s0_op_q == OpWrite) && s0_adv &&
                   (int'(s0_idx_q) < int'(NumSlots));
  assign wr_slot = s0_idx_q[SlotW-1:0];

  assign eff_cnt = (seg_cnt_q > CntW'(NumSlots)) ? CntW'(NumSlots) : seg_cnt_q;

  // parallel start compare over all slots in use
  always_comb begin
    for (int i = 0; i < int'(NumSlots); i++) begin
      hit[i] = (CntW'(i) < eff_cnt) && (start_q[i] <= s0_x_q);
    end
  end

  // highest matching slot wins
  always_comb begin
    found = '0;
    for (int i = 0; i < int'(NumSlots); i++) begin
      if (hit[i]) begin
        found = SlotW'(i);
      end
    end
  end

  assign any = |hit;

  assign job_valid_o     = s1_v_q;
  assign job_o.x         = s1_x_q;
  assign job_o.rx        = refx_q[s1_found_q];
  assign job_o.ry        = refy_q[s1_found_q];
  assign job_o.slope     = slope_q[s1_found_q];
  assign job_o.in_domain = s1_any_q && (s1_x_q <= end_q[s1_found_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q    <= 1'b0;
      s1_v_q    <= 1'b0;
      seg_cnt_q <= '0;
    end else begin
      if (s0_adv) begin
        s0_v_q <= accept;
      end
      if (s1_adv) begin
        s1_v_q <= s0_v_q && (s0_op_q == OpEval);
      end
      if (cfg_we_i) begin
        seg_cnt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_op_q    <= pwle_op_e'(op_i);
      s0_idx_q   <= entry_index_i;
      s0_start_q <= start_x_i;
      s0_end_q   <= end_x_i;
      s0_refx_q  <= ref_x_i;
      s0_refy_q  <= ref_y_i;
      s0_slope_q <= slope_i;
      s0_x_q     <= query_x_i;
    end
    if (s1_adv) begin
      s1_any_q   <= any;
      s1_found_q <= found;
      s1_x_q     <= s0_x_q;
    end
    if (tbl_we) begin
      start_q[wr_slot] <= s0_start_q;
      end_q[wr_slot]   <= s0_end_q;
      refx_q[wr_slot]  <= s0_refx_q;
      refy_q[wr_slot]  <= s0_refy_q;
      slope_q[wr_slot] <= s0_slope_q;
    end
  end

endmodule

FILE: hw/rtl/pwle_back.sv
module pwle_back import pwle_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  pwle_job_t          job_i,
  output logic               job_pop_o,
  input  logic [OutCntW-1:0] out_count_i,
  output logic               res_valid_o,
  output pwle_res_t          res_o
);

  // stage a: span and slope magnitudes
  logic                    a_v_q, a_neg_q, a_dom_q;
  logic [DataW-1:0]        a_span_q, a_sl_q;
  logic signed [DataW-1:0] a_ry_q;
  // stage b: partial products
  logic                    b_v_q, b_neg_q, b_dom_q;
  logic [DataW-1:0]        b_p00_q, b_p01_q, b_p10_q, b_p11_q;
  logic signed [DataW-1:0] b_ry_q;
  // stage c: full magnitude product
  logic                    c_v_q, c_neg_q, c_dom_q;
  logic [2*DataW-1:0]      c_prod_q;
  logic signed [DataW-1:0] c_ry_q;
  // stage d: signed product
  logic                    d_v_q, d_dom_q;
  logic [2*DataW:0]        d_sp_q;
  logic signed [DataW-1:0] d_ry_q;

  logic                    span_neg, sl_neg;
  logic [DataW-1:0]        span_mag, sl_mag;
  logic [2*DataW-1:0]      prod;
  logic [2*DataW:0]        sprod;
  logic [2*DataW+1:0]      sum;
  logic                    fits;
  logic signed [DataW-1:0] sat;
  logic [2:0]              inflight;
  logic                    credit_ok;

  // never start more jobs than the result queue can still hold
  assign inflight  = 3'(a_v_q) + 3'(b_v_q) + 3'(c_v_q) + 3'(d_v_q);
  assign credit_ok = (int'(out_count_i) + int'(inflight)) < int'(OutQDepth);
  assign job_pop_o = job_valid_i && credit_ok;

  assign span_neg = job_i.x < job_i.rx;
  assign span_mag = span_neg ? DataW'(job_i.rx - job_i.x) : DataW'(job_i.x - job_i.rx);
  assign sl_neg   = job_i.slope[DataW-1];
  assign sl_mag   = sl_neg ? (DataW'(0) - DataW'(job_i.slope)) : DataW'(job_i.slope);

  assign prod = {{DataW{1'b0}}, b_p00_q}
              + {{(DataW/2){1'b0}}, b_p01_q, {(DataW/2){1'b0}}}
              + {{(DataW/2){1'b0}}, b_p10_q, {(DataW/2){1'b0}}}
              + {b_p11_q, {DataW{1'b0}}};

  assign sprod = c_neg_q ? ((2*DataW+1)'(0) - {1'b0, c_prod_q}) : {1'b0, c_prod_q};

  assign sum  = {d_sp_q[2*DataW], d_sp_q} + {{(DataW+2){d_ry_q[DataW-1]}}, d_ry_q};
  assign fits = (&sum[2*DataW+1:DataW-1]) || !(|sum[2*DataW+1:DataW-1]);
  assign sat  = fits ? DataW'(sum[DataW-1:0]) : (sum[2*DataW+1] ? KInt64Min : KInt64Max);

  assign res_valid_o     = d_v_q;
  assign res_o.value     = d_dom_q ? sat : KInt64Max;
  assign res_o.in_domain = d_dom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      a_v_q <= job_pop_o;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_span_q <= span_mag;
    a_sl_q   <= sl_mag;
    a_neg_q  <= span_neg ^ sl_neg;
    a_ry_q   <= job_i.ry;
    a_dom_q  <= job_i.in_domain;

    b_p00_q  <= DataW'(a_span_q[DataW/2-1:0]) * DataW'(a_sl_q[DataW/2-1:0]);
    b_p01_q  <= DataW'(a_span_q[DataW/2-1:0]) * DataW'(a_sl_q[DataW-1:DataW/2]);
    b_p10_q  <= DataW'(a_span_q[DataW-1:DataW/2]) * DataW'(a_sl_q[DataW/2-1:0]);
    b_p11_q  <= DataW'(a_span_q[DataW-1:DataW/2]) * DataW'(a_sl_q[DataW-1:DataW/2]);
    b_neg_q  <= a_neg_q;
    b_ry_q   <= a_ry_q;
    b_dom_q  <= a_dom_q;

    c_prod_q <= prod;
    c_neg_q  <= b_neg_q;
    c_ry_q   <= b_ry_q;
    c_dom_q  <= b_dom_q;

    d_sp_q   <= sprod;
    d_ry_q   <= c_ry_q;
    d_dom_q  <= c_dom_q;
  end

endmodule

FILE: hw/rtl/piecewise_linear_evaluate_unit.sv
// path: an input transfer passes the input and classify stages, the mid queue,
// back stages a to d and the result queue; the result side can hold it up
// throughput: one item per cycle while results are popped, set by the front table
// compare and the four-stage split 64x64 multiply; write items leave no result
// reset: rst_ni async active low clears queues, pipeline valids and segment_count;
// the segment table is not cleared and holds garbage until written
module piecewise_linear_evaluate_unit import pwle_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = MaxSegmentsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input side, looks like a queue write port
  input  logic                    push,
  output logic                    full,
  input  logic                    op_i,
  input  logic [EntryIdxW-1:0]    entry_index_i,
  input  logic signed [DataW-1:0] start_x_i,
  input  logic signed [DataW-1:0] end_x_i,
  input  logic signed [DataW-1:0] ref_x_i,
  input  logic signed [DataW-1:0] ref_y_i,
  input  logic signed [DataW-1:0] slope_i,
  input  logic signed [DataW-1:0] query_x_i,
  // segment_count register
  input  logic                    cfg_we_i,
  input  logic [CntW-1:0]         cfg_wdata_i,
  // result side, looks like a queue read port
  output logic                    empty,
  input  logic                    pop,
  output logic signed [DataW-1:0] value_o,
  output logic                    in_domain_o
);

  // front to back job channel
  pwle_job_t                  job, mid_head;
  logic                       job_valid, job_full;
  logic [$bits(pwle_job_t)-1:0] mid_head_bits;
  logic                       mid_empty, job_pop;

  // back to result queue
  pwle_res_t                  res, res_head;
  logic [$bits(pwle_res_t)-1:0] res_head_bits;
  logic                       res_valid, out_full;
  logic [OutCntW-1:0]         out_count;

  // front: input transfer, table writes, start compare and segment pick
  pwle_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .start_x_i     (start_x_i),
    .end_x_i       (end_x_i),
    .ref_x_i       (ref_x_i),
    .ref_y_i       (ref_y_i),
    .slope_i       (slope_i),
    .query_x_i     (query_x_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .job_valid_o   (job_valid),
    .job_o         (job),
    .job_full_i    (job_full)
  );

  // short decoupling queue, carries the chosen segment with the query
  pwle_queue #(
    .WIDTH ($bits(pwle_job_t)),
    .DEPTH (MidQDepth)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .data_i  (job),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (mid_head_bits),
    .empty_o (mid_empty),
    .count_o ()
  );

  assign mid_head = pwle_job_t'(mid_head_bits);

  // back: exact multiply-add and saturation, pops on credit only
  pwle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!mid_empty),
    .job_i       (mid_head),
    .job_pop_o   (job_pop),
    .out_count_i (out_count),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result queue, its head drives the result ports
  pwle_queue #(
    .WIDTH ($bits(pwle_res_t)),
    .DEPTH (OutQDepth)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (res_head_bits),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign res_head    = pwle_res_t'(res_head_bits);
  assign value_o     = res_head.value;
  assign in_domain_o = res_head.in_domain;

  // the credit scheme must keep the result queue from ever overflowing
  a_no_out_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !out_full)
    else $error("result queue overflow");

  // the back only pops a job that is there
  a_pop_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !mid_empty)
    else $error("job popped from empty queue");

  // an out-of-domain result always carries the int64 maximum
  a_out_of_domain_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !in_domain_o) |-> (value_o == KInt64Max))
    else $error("out-of-domain result with wrong value");

endmodule

FILE: bench/piecewise_linear_evaluate_unit_test.sv
`timescale 1ns / 100ps

module piecewise_linear_evaluate_unit_test;
  import pwle_pkg::*;

  // clock, reset and run limits
  localparam int unsigned HalfPeriod    = 4;
  localparam int unsigned ResetCycles   = 10;
  localparam int unsigned SettleCycles  = 12;    // well past the pipeline depth
  localparam int unsigned WatchdogLimit = 3000;  // cycles without any transfer
  localparam int unsigned TargetItems   = 1230;

  // one input item as seen on the push side
  typedef struct {
    pwle_op_e                op;
    logic [EntryIdxW-1:0]    entry_index;
    logic signed [DataW-1:0] start_x;
    logic signed [DataW-1:0] end_x;
    logic signed [DataW-1:0] ref_x;
    logic signed [DataW-1:0] ref_y;
    logic signed [DataW-1:0] slope;
    logic signed [DataW-1:0] query_x;
  } seg_item_t;

  // shadow of the segment table, segment_count and the results still owed
  class pwl_scoreboard;
    logic signed [DataW-1:0] seg_start [MaxSegmentsDef];
    logic signed [DataW-1:0] seg_end   [MaxSegmentsDef];
    logic signed [DataW-1:0] seg_refx  [MaxSegmentsDef];
    logic signed [DataW-1:0] seg_refy  [MaxSegmentsDef];
    logic signed [DataW-1:0] seg_slope [MaxSegmentsDef];
    logic [CntW-1:0]         seg_count = '0;
    pwle_res_t               owed_q[$];
    int n_errors = 0, n_evals = 0, n_checked = 0, n_in_domain = 0, n_saturated = 0;

    // ref_y + slope * (x - ref_x), exact in 132 bits, then clamped to 64
    function logic signed [DataW-1:0] line_value(int i, logic signed [DataW-1:0] x);
      logic signed [131:0] acc;
      acc = x;
      acc = acc - seg_refx[i];
      acc = acc * seg_slope[i] + seg_refy[i];
      if (acc > KInt64Max) begin
        n_saturated++;
        return KInt64Max;
      end
      if (acc < KInt64Min) begin
        n_saturated++;
        return KInt64Min;
      end
      return acc[DataW-1:0];
    endfunction

    function void note_transfer(seg_item_t it);
      int lim, hit, i;
      pwle_res_t want;
      if (it.op == OpWrite) begin
        seg_start[it.entry_index] = it.start_x;
        seg_end[it.entry_index]   = it.end_x;
        seg_refx[it.entry_index]  = it.ref_x;
        seg_refy[it.entry_index]  = it.ref_y;
        seg_slope[it.entry_index] = it.slope;
        return;
      end
      n_evals++;
      // counts above the table depth behave as a full table
      lim = (seg_count > MaxSegmentsDef) ? MaxSegmentsDef : seg_count;
      hit = -1;
      for (i = 0; i < lim; i++) begin
        if (seg_start[i] <= it.query_x) hit = i;
      end
      if (hit < 0 || it.query_x > seg_end[hit]) begin
        want.value     = KInt64Max;
        want.in_domain = 1'b0;
      end else begin
        want.value     = line_value(hit, it.query_x);
        want.in_domain = 1'b1;
      end
      owed_q.insert(owed_q.size(), want);
    endfunction

    function void check_result(logic signed [DataW-1:0] value, logic in_domain);
      pwle_res_t want;
      if (owed_q.size() == 0) begin
        $error("result transfer with nothing owed: value %0d, in_domain %0b",
               value, in_domain);
        n_errors++;
        return;
      end
      want = owed_q.pop_front();
      n_checked++;
      if (want.in_domain) n_in_domain++;
      if (value !== want.value) begin
        $error("value mismatch: expected %0d, got %0d", want.value, value);
        n_errors++;
      end
      if (in_domain !== want.in_domain) begin
        $error("in_domain mismatch: expected %0b, got %0b", want.in_domain, in_domain);
        n_errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  // every input starts at a known value
  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    push          = 1'b0;
  logic                    full;
  logic                    op_i          = OpWrite;
  logic [EntryIdxW-1:0]    entry_index_i = '0;
  logic signed [DataW-1:0] start_x_i     = '0;
  logic signed [DataW-1:0] end_x_i       = '0;
  logic signed [DataW-1:0] ref_x_i       = '0;
  logic signed [DataW-1:0] ref_y_i       = '0;
  logic signed [DataW-1:0] slope_i       = '0;
  logic signed [DataW-1:0] query_x_i     = '0;
  logic                    cfg_we_i      = 1'b0;
  logic [CntW-1:0]         cfg_wdata_i   = '0;
  logic                    empty;
  logic                    pop           = 1'b0;
  logic signed [DataW-1:0] value_o;
  logic                    in_domain_o;

  pwl_scoreboard sb = new;

  // idling percentages for each side, changed from phase to phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_items = 0, n_cfg = 0, n_loads = 0, n_phases = 0;
  int idle_cycles = 0;

  piecewise_linear_evaluate_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .entry_index_i (entry_index_i),
    .start_x_i     (start_x_i),
    .end_x_i       (end_x_i),
    .ref_x_i       (ref_x_i),
    .ref_y_i       (ref_y_i),
    .slope_i       (slope_i),
    .query_x_i     (query_x_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .empty         (empty),
    .pop           (pop),
    .value_o       (value_o),
    .in_domain_o   (in_domain_o)
  );

  always begin
    clk_i = 1'b0;
    #HalfPeriod;
    clk_i = 1'b1;
    #HalfPeriod;
  end

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [DataW-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // signed value in [-r, r]
  function automatic logic signed [DataW-1:0] near_zero(int unsigned r);
    logic signed [DataW-1:0] v;
    v = $urandom_range(2 * r);
    return v - r;
  endfunction

  // gap only idle_pct percent of the time, mostly short with the odd long one
  function automatic int pick_gap(int idle_pct);
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 10;
      2:       return 35;
      default: return 70;
    endcase
  endfunction

  // query points cluster on segment boundaries, with some wild ones
  function automatic logic signed [DataW-1:0] pick_query();
    int j;
    logic signed [DataW-1:0] s, e;
    logic [DataW-1:0] span, off;
    j = $urandom_range(MaxSegmentsDef - 1);
    s = sb.seg_start[j];
    e = sb.seg_end[j];
    case ($urandom_range(11))
      0:    return s - 1;
      1, 2: return s;
      3, 4: return e;
      5:    return e + 1;
      6, 7, 8: begin
        if (e < s) return s;
        span = e - s;
        off  = rand64();
        if (span != '1) off = off % (span + 1);
        return s + off;
      end
      9:       return rand64();
      10:      return $urandom_range(1) ? KInt64Min : KInt64Max;
      default: return near_zero(3);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // push side
  // ---------------------------------------------------------------------------

  // present one item at a falling edge and hold it until the transfer;
  // returns at the next falling edge with push still high
  task automatic drive_item(seg_item_t it);
    int gap;
    gap = pick_gap(send_idle_pct);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push          <= 1'b1;
    op_i          <= it.op;
    entry_index_i <= it.entry_index;
    start_x_i     <= it.start_x;
    end_x_i       <= it.end_x;
    ref_x_i       <= it.ref_x;
    ref_y_i       <= it.ref_y;
    slope_i       <= it.slope;
    query_x_i     <= it.query_x;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_transfer(it);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic send_write(int idx, logic signed [DataW-1:0] s, logic signed [DataW-1:0] e,
                            logic signed [DataW-1:0] rx, logic signed [DataW-1:0] ry,
                            logic signed [DataW-1:0] sl);
    seg_item_t it;
    it.op          = OpWrite;
    it.entry_index = EntryIdxW'(idx);
    it.start_x     = s;
    it.end_x       = e;
    it.ref_x       = rx;
    it.ref_y       = ry;
    it.slope       = sl;
    it.query_x     = rand64();   // ignored by a write, toggles the port anyway
    drive_item(it);
  endtask

  task automatic send_eval(logic signed [DataW-1:0] x);
    seg_item_t it;
    it.op          = OpEval;
    it.entry_index = EntryIdxW'($urandom_range(MaxSegmentsDef - 1));
    it.start_x     = rand64();
    it.end_x       = rand64();
    it.ref_x       = rand64();
    it.ref_y       = rand64();
    it.slope       = rand64();
    it.query_x     = x;
    drive_item(it);
  endtask

  // segment_count is only written once the pipeline has fully drained;
  // write items leave no result, so allow the pipeline depth on top
  task automatic set_segment_count(logic [CntW-1:0] c);
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    sb.seg_count = c;
    n_cfg++;
  endtask

  // ascending, non-overlapping segments in all 16 slots; the scale k decides
  // whether the inner segments are single points or up to 2**57 values wide
  task automatic load_sorted_segments();
    int k, i;
    logic [DataW-1:0] mask;
    logic signed [DataW-1:0] cursor, len, gap, s, e, rx, ry, sl;
    k      = $urandom_range(57);
    mask   = (64'd1 << k) - 64'd1;
    cursor = -(64'sd1 <<< (k + 4));
    cursor = cursor + (rand64() & mask);
    for (i = 0; i < MaxSegmentsDef; i++) begin
      len = rand64() & mask;
      gap = rand64() & mask;   // zero gives touching segments
      s   = cursor;
      e   = cursor + len;
      if (i == 0 && $urandom_range(7) == 0) s = KInt64Min;
      if (i == MaxSegmentsDef - 1 && $urandom_range(7) == 0) e = KInt64Max;
      case ($urandom_range(3))
        0:       rx = s;
        1:       rx = e;
        2:       rx = rand64();
        default: rx = s + near_zero(50);
      endcase
      case ($urandom_range(4))
        0, 1:    ry = near_zero(1000);
        2:       ry = rand64();
        3:       ry = KInt64Max;
        default: ry = KInt64Min;
      endcase
      case ($urandom_range(6))
        0, 1:    sl = near_zero(100);
        2:       sl = rand64();
        3:       sl = KInt64Max;
        4:       sl = KInt64Min;
        5:       sl = '0;
        default: sl = $urandom_range(1) ? 64'sd1 : -64'sd1;
      endcase
      send_write(i, s, e, rx, ry, sl);
      cursor = e + 1 + gap;
    end
    n_loads++;
  endtask

  // unsorted and overlapping entries over a part of the table
  task automatic scramble_segments();
    int n;
    logic signed [DataW-1:0] s;
    n = $urandom_range(4, MaxSegmentsDef);
    repeat (n) begin
      if ($urandom_range(1)) begin
        s = near_zero(1000);
        send_write($urandom_range(MaxSegmentsDef - 1), s, s + $urandom_range(2000),
                   s + near_zero(20), near_zero(1000), near_zero(10));
      end else begin
        send_write($urandom_range(MaxSegmentsDef - 1), rand64(), rand64(),
                   rand64(), rand64(), rand64());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // directed part: empty table, a hand-built table, count limits
  // ---------------------------------------------------------------------------

  task automatic run_directed();
    int i;
    logic signed [DataW-1:0] s;
    // empty table after reset: everything is outside the domain
    send_eval(KInt64Min);
    send_eval('0);
    send_eval(KInt64Max);
    // segment i covers [(i-8)*1000, +499] with gaps in between;
    // the first and last slots reach the ends of the range with steep slopes
    for (i = 0; i < MaxSegmentsDef; i++) begin
      s = (i - 8) * 1000;
      if (i == 0) begin
        send_write(i, KInt64Min, -64'sd7501, '0, KInt64Min, KInt64Max);
      end else if (i == MaxSegmentsDef - 1) begin
        send_write(i, 64'sd7000, KInt64Max, 64'sd7000, KInt64Max - 64'sd5, KInt64Max);
      end else begin
        send_write(i, s, s + 499, s, i * 7, i - 8);
      end
    end
    n_loads++;
    set_segment_count(CntW'(MaxSegmentsDef));
    send_eval(KInt64Min);     // saturates low
    send_eval(-64'sd7000);    // start of a segment
    send_eval(-64'sd6501);    // inclusive end of a segment
    send_eval(-64'sd6500);    // gap between segments
    send_eval(64'sd7000);     // reference point of the last segment
    send_eval(64'sd7001);     // saturates high
    send_eval(KInt64Max);
    // count beyond the table depth
    set_segment_count('1);
    send_eval(-64'sd3000);
    // only the first segment in use: later points lie past its end
    set_segment_count(CntW'(1));
    send_eval(-64'sd7000);
  endtask

  task automatic run_random_phase();
    logic [CntW-1:0] c;
    int n, sel;
    case ($urandom_range(9))
      0:       c = '0;
      1:       c = CntW'(1);
      2, 3:    c = CntW'(MaxSegmentsDef);
      4:       c = CntW'(MaxSegmentsDef + 1);
      5:       c = '1;
      default: c = CntW'($urandom_range(2, MaxSegmentsDef - 1));
    endcase
    send_idle_pct = pick_idle_pct();
    recv_idle_pct = pick_idle_pct();
    set_segment_count(c);
    sel = $urandom_range(9);
    if (sel < 5) load_sorted_segments();
    else if (sel == 5) scramble_segments();
    n = $urandom_range(20, 80);
    repeat (n) begin
      if ($urandom_range(99) < 4) begin
        send_write($urandom_range(MaxSegmentsDef - 1), rand64(), rand64(),
                   rand64(), rand64(), rand64());
      end else begin
        send_eval(pick_query());
      end
    end
    n_phases++;
  endtask

  // ---------------------------------------------------------------------------
  // pop side: stalls of random length, checked at the rising edge
  // ---------------------------------------------------------------------------

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        stall_left = pick_gap(recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_result(value_o, in_domain_o);
  end

  // watchdog: too long without a transfer on either side means a hang
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WatchdogLimit) begin
      $display("piecewise_linear_evaluate_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    while (n_items < TargetItems) run_random_phase();
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    $display("%0d items sent, %0d evaluations, %0d results checked",
             n_items, sb.n_evals, sb.n_checked);
    $display("%0d in domain, %0d saturated, %0d random phases, %0d count writes, %0d loads",
             sb.n_in_domain, sb.n_saturated, n_phases, n_cfg, n_loads);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("piecewise_linear_evaluate_unit test passed");
    end else begin
      $display("piecewise_linear_evaluate_unit test failed");
    end
    $finish;
  end

endmodule
